/* rtl/core/lseg_pkg.sv */
// package: types, codes and arithmetic helpers for the led strip effect generator
`timescale 1ns / 1ps
package lseg_pkg;

  localparam int IDX_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int LED_COUNT_DEF = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 3'd6;

  // effect codes
  localparam logic [4:0] FX_OFF = 5'd0;
  localparam logic [4:0] FX_SOLID = 5'd1;
  localparam logic [4:0] FX_CHASE = 5'd4;
  localparam logic [4:0] FX_SCANNER = 5'd5;
  localparam logic [4:0] FX_COMET = 5'd7;
  localparam logic [4:0] FX_WIPE = 5'd8;
  localparam logic [4:0] FX_THEATER = 5'd9;
  localparam logic [4:0] FX_TWINKLE = 5'd10;
  localparam logic [4:0] FX_METEOR = 5'd11;
  localparam logic [4:0] FX_DUAL = 5'd13;
  localparam logic [4:0] FX_HEART = 5'd14;
  localparam logic [4:0] FX_CYBER = 5'd15;
  localparam logic [4:0] FX_COUNT = 5'd23;

  typedef struct packed {
    logic load_now;
    logic start_frame;
    logic issue;
    logic finish;
  } lseg_cmd_t;

  typedef struct packed {
    logic due;
    logic pix_last;
    logic stall;
  } lseg_sts_t;

  // 220 - 202*(s-1)/99, the /99 done as *662 >> 16 (exact below 20000)
  function automatic logic [7:0] interval_of(input logic [6:0] s);
    logic [14:0] x;
    logic [24:0] p;
    begin
      x = 15'(15'd202 * 15'(s - 7'd1));
      p = 25'(x) * 25'd662;
      interval_of = 8'(9'd220 - 9'(p[24:16]));
    end
  endfunction

  // x/255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    begin
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      div255 = t[15:8];
    end
  endfunction

  function automatic logic [6:0] absdiff(input logic [6:0] a, input logic [6:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [7:0] heart_level(input logic [4:0] ph);
    unique case (ph)
      5'd1: heart_level = 8'd210;
      5'd2: heart_level = 8'd255;
      5'd3: heart_level = 8'd95;
      5'd6: heart_level = 8'd175;
      5'd7: heart_level = 8'd225;
      5'd8: heart_level = 8'd65;
      default: heart_level = 8'd10;
    endcase
  endfunction

endpackage

/* rtl/core/lseg_if.sv */
// channel interfaces: time stamp input and pixel output
`timescale 1ns / 1ps
interface lseg_in_if;
  logic valid;
  logic ready;
  logic [31:0] now_ms;
  modport source (output valid, output now_ms, input ready);
  modport sink (input valid, input now_ms, output ready);
endinterface

interface lseg_out_if;
  logic valid;
  logic ready;
  logic [5:0] pixel_index;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic frame_last;
  modport source (output valid, output pixel_index, output pixel_red, output pixel_green,
                  output pixel_blue, output frame_last, input ready);
  modport sink (input valid, input pixel_index, input pixel_red, input pixel_green,
                input pixel_blue, input frame_last, output ready);
endinterface

/* rtl/core/lseg_ctrl.sv */
// frame sequencer state machine
`timescale 1ns / 1ps
module lseg_ctrl import lseg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lseg_sts_t  sts,
  output lseg_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_RENDER = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_now = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.due) begin
          cmd.start_frame = 1'b1;
          state_nxt = ST_RENDER;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RENDER: begin
        if (!sts.stall) begin
          cmd.issue = 1'b1;
          if (sts.pix_last) begin
            cmd.finish = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/lseg_datapath.sv */
// registers, animation state, pixel level logic and colour scaling pipeline
`timescale 1ns / 1ps
module lseg_datapath import lseg_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [31:0]           now_ms,
  input  lseg_cmd_t             cmd,
  output lseg_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_W-1:0]      out_index,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  out_last
);

  localparam logic [6:0] N = 7'(LED_COUNT);
  localparam logic [6:0] N_M1 = 7'(LED_COUNT - 1);
  localparam logic [6:0] N2_M1 = 7'(2 * LED_COUNT - 1);
  localparam logic [IDX_W-1:0] LAST_PIX = IDX_W'(LED_COUNT - 1);
  localparam logic [15:0] WIPE_N = 16'(LED_COUNT);
  localparam logic [15:0] WIPE_N1 = 16'(LED_COUNT + 1);
  localparam logic [15:0] WIPE_TOP = 16'(2 * LED_COUNT + 1);

  // configuration
  logic       enable_r;
  logic [4:0] effect_r;
  logic [7:0] red_r, green_r, blue_r, bright_r;
  logic [7:0] interval_r;

  // animation state
  logic [31:0] last_r, now_r;
  logic [15:0] step_r;
  logic [5:0]  head_r;    // step mod n
  logic [2:0]  lap6_r;    // (step / n) mod 6
  logic [6:0]  m2n_r;     // step mod 2n
  logic [1:0]  m3_r;
  logic [4:0]  m28_r;
  logic [5:0]  scan_r;
  logic        down_r;

  // per frame counters
  logic [IDX_W-1:0] pix_r;
  logic [1:0]       pm3_r;
  logic [7:0]       tw_r;

  logic [4:0] eff_wr;
  logic [6:0] spd_wr;
  logic       clear_anim;
  logic       dark, adv;

  always_comb begin
    eff_wr = (cfg_data[4:0] >= FX_COUNT) ? cfg_data[4:0] - FX_COUNT : cfg_data[4:0];
    spd_wr = cfg_data[6:0];
    if (spd_wr < 7'd1) spd_wr = 7'd1;
    if (spd_wr > 7'd100) spd_wr = 7'd100;
    clear_anim = cfg_we && (cfg_index == REG_EFFECT) && (eff_wr != effect_r);
    dark = !enable_r || (effect_r == FX_OFF) || (bright_r == 8'd0);
    adv = !dark && ((effect_r == FX_CHASE) || (effect_r == FX_COMET) ||
          (effect_r == FX_THEATER) || (effect_r == FX_TWINKLE) ||
          (effect_r == FX_METEOR) || (effect_r == FX_DUAL) ||
          (effect_r == FX_HEART) || (effect_r == FX_CYBER));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      effect_r <= FX_SOLID;
      red_r <= 8'd255;
      green_r <= 8'd255;
      blue_r <= 8'd255;
      bright_r <= 8'd255;
      interval_r <= interval_of(7'd50);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: enable_r <= cfg_data[0];
        REG_EFFECT: effect_r <= eff_wr;
        REG_RED:    red_r <= cfg_data;
        REG_GREEN:  green_r <= cfg_data;
        REG_BLUE:   blue_r <= cfg_data;
        REG_BRIGHT: bright_r <= cfg_data;
        REG_SPEED:  interval_r <= interval_of(spd_wr);
        default: ;
      endcase
    end
  end

  // wipe sequence values
  logic [15:0] wipe_head, wipe_nxt;
  logic [6:0]  vh;
  always_comb begin
    wipe_head = (step_r <= WIPE_N) ? step_r : step_r - WIPE_N1;
    wipe_nxt = (step_r >= WIPE_TOP) ? 16'd0 : step_r + 16'd1;
    vh = (m2n_r < N) ? m2n_r : N2_M1 - m2n_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      step_r <= '0;
      head_r <= '0;
      lap6_r <= '0;
      m2n_r <= '0;
      m3_r <= '0;
      m28_r <= '0;
      scan_r <= '0;
      down_r <= 1'b0;
    end else if (clear_anim) begin
      step_r <= '0;
      head_r <= '0;
      lap6_r <= '0;
      m2n_r <= '0;
      m3_r <= '0;
      m28_r <= '0;
      scan_r <= '0;
      down_r <= 1'b0;
    end else begin
      if (cmd.start_frame) last_r <= now_r;
      if (cmd.finish) begin
        if (adv) begin
          step_r <= step_r + 16'd1;
          // step wraps to zero, so every residue restarts at zero
          if (step_r == 16'hFFFF) begin
            head_r <= '0;
            lap6_r <= '0;
            m2n_r <= '0;
            m3_r <= '0;
            m28_r <= '0;
          end else begin
            if ({1'b0, head_r} == N_M1) begin
              head_r <= '0;
              lap6_r <= (lap6_r == 3'd5) ? 3'd0 : lap6_r + 3'd1;
            end else begin
              head_r <= head_r + 6'd1;
            end
            m2n_r <= (m2n_r == N2_M1) ? 7'd0 : m2n_r + 7'd1;
            m3_r <= (m3_r == 2'd2) ? 2'd0 : m3_r + 2'd1;
            m28_r <= (m28_r == 5'd27) ? 5'd0 : m28_r + 5'd1;
          end
        end
        if (!dark && effect_r == FX_WIPE) step_r <= wipe_nxt;
        if (!dark && effect_r == FX_SCANNER) begin
          if (down_r) begin
            if (scan_r <= 6'd1) begin
              scan_r <= '0;
              down_r <= 1'b0;
            end else begin
              scan_r <= scan_r - 6'd1;
            end
          end else if ({1'b0, scan_r} + 7'd1 >= N_M1) begin
            scan_r <= 6'(N_M1);
            down_r <= 1'b1;
          end else begin
            scan_r <= scan_r + 6'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_now) now_r <= now_ms;
    if (cmd.start_frame) begin
      pix_r <= '0;
      pm3_r <= '0;
      tw_r <= 8'(step_r[7:0] * 8'd11);
    end else if (cmd.issue) begin
      pix_r <= pix_r + IDX_W'(1);
      pm3_r <= (pm3_r == 2'd2) ? 2'd0 : pm3_r + 2'd1;
      tw_r <= tw_r + 8'd37;
    end
  end

  // level of the pixel being issued
  logic [6:0] i7, dd, d1, d2;
  logic [7:0] lv;
  always_comb begin
    i7 = {1'b0, pix_r};
    dd = '0;
    d1 = '0;
    d2 = '0;
    lv = 8'd0;
    if (!dark) begin
      unique case (effect_r)
        FX_SOLID: lv = 8'd255;
        FX_CHASE: begin
          dd = (i7 >= {1'b0, head_r}) ? i7 - {1'b0, head_r} : i7 + N - {1'b0, head_r};
          lv = (dd == 7'd0) ? 8'd255 : (dd == 7'd1) ? 8'd80 : 8'd12;
        end
        FX_SCANNER: begin
          dd = absdiff(i7, {1'b0, scan_r});
          lv = (dd == 7'd0) ? 8'd255 : (dd == 7'd1) ? 8'd85 : 8'd8;
        end
        FX_COMET: begin
          dd = ({1'b0, head_r} >= i7) ? {1'b0, head_r} - i7 : {1'b0, head_r} + N - i7;
          lv = (dd == 7'd0) ? 8'd255 : (dd == 7'd1) ? 8'd150 :
               (dd == 7'd2) ? 8'd70 : (dd == 7'd3) ? 8'd25 : 8'd0;
        end
        FX_WIPE: begin
          if (wipe_nxt > WIPE_N) begin
            lv = ({9'd0, i7} <= wipe_nxt - WIPE_N1) ? 8'd0 : 8'd255;
          end else begin
            lv = ({9'd0, i7} < wipe_head) ? 8'd255 : 8'd0;
          end
        end
        FX_THEATER: lv = (pm3_r == m3_r) ? 8'd255 : 8'd10;
        FX_TWINKLE: lv = (tw_r > 8'd225) ? 8'd255 : (tw_r > 8'd185) ? 8'd75 : 8'd7;
        FX_METEOR: begin
          dd = absdiff(i7, vh);
          lv = (dd == 7'd0) ? 8'd255 : (dd == 7'd1) ? 8'd145 :
               (dd == 7'd2) ? 8'd55 : 8'd6;
        end
        FX_DUAL: begin
          d1 = absdiff(i7, {1'b0, head_r});
          d2 = absdiff(i7, N_M1 - {1'b0, head_r});
          dd = (d1 < d2) ? d1 : d2;
          lv = (dd == 7'd0) ? 8'd255 : (dd == 7'd1) ? 8'd72 : 8'd5;
        end
        FX_HEART: lv = heart_level(m28_r);
        FX_CYBER: begin
          dd = (i7 >= {1'b0, head_r}) ? i7 - {1'b0, head_r} : i7 + N - {1'b0, head_r};
          lv = (dd == 7'd0) ? 8'd255 : (dd == 7'd1) ? 8'd110 :
               (dd == 7'd2) ? 8'd38 : 8'd5;
          if (lap6_r == 3'd5 && !pix_r[0]) lv = 8'd180;
        end
        default: lv = 8'd0;
      endcase
    end
  end

  // three stage scaling pipeline, moves only when the output slot frees
  logic             go;
  logic             s1_v_r, s2_v_r;
  logic [7:0]       s1_lv_r, s2_sc_r;
  logic [IDX_W-1:0] s1_idx_r, s2_idx_r;
  logic             s1_last_r, s2_last_r;

  assign go = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (go) begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      out_valid <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_lv_r <= lv;
      s1_idx_r <= pix_r;
      s1_last_r <= (pix_r == LAST_PIX);
      s2_sc_r <= div255(16'(bright_r) * 16'(s1_lv_r));
      s2_idx_r <= s1_idx_r;
      s2_last_r <= s1_last_r;
      out_red <= div255(16'(red_r) * 16'(s2_sc_r));
      out_green <= div255(16'(green_r) * 16'(s2_sc_r));
      out_blue <= div255(16'(blue_r) * 16'(s2_sc_r));
      out_index <= s2_idx_r;
      out_last <= s2_last_r;
    end
  end

  always_comb begin
    sts.due = (now_r - last_r) >= {24'd0, interval_r};
    sts.pix_last = (pix_r == LAST_PIX);
    sts.stall = !go;
  end

endmodule

/* rtl/core/led_strip_effect_generator_core.sv */
// top level of the led strip effect generator
// Usage: each transfer on in_ch carries a millisecond time stamp now_ms.
// When the wrapping difference to the last frame time reaches the frame
// interval set by the speed register, a frame of LED_COUNT pixels is sent on out_ch
// in strip order, frame_last marking the final pixel; otherwise the tick
// gives nothing. When a frame is due, the sequencer issues one pixel per
// cycle while out_ch is not stalled, each pixel passing in turn through the
// three stage scaling pipeline (s1, s2, output registers). Ticks are taken
// one at a time; in_ch.ready is high only while the sequencer is idle.
// When out_ch stalls, the pipeline and the pixel sequencer hold, and no
// pixel is lost. Registers are written through cfg_we/cfg_index/cfg_data;
// the user is to write them only while idle; the block itself does not
// enforce this. Writing a new effect restarts the animation.
// Synchronous reset restores the register defaults (on, solid, white,
// full brightness, speed 50) and clears the animation state.
`timescale 1ns / 1ps
module led_strip_effect_generator_core import lseg_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lseg_in_if.sink               in_ch,
  lseg_out_if.source            out_ch
);

  lseg_cmd_t cmd;
  lseg_sts_t sts;

  lseg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lseg_datapath #(.LED_COUNT(LED_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .now_ms    (in_ch.now_ms),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_index (out_ch.pixel_index),
    .out_red   (out_ch.pixel_red),
    .out_green (out_ch.pixel_green),
    .out_blue  (out_ch.pixel_blue),
    .out_last  (out_ch.frame_last)
  );

  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second tick taken right after a transfer");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_last |-> out_ch.pixel_index == IDX_W'(LED_COUNT - 1))
    else $error("frame_last on a pixel other than the final one");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.pixel_index <= IDX_W'(LED_COUNT - 1))
    else $error("pixel index beyond strip length");

endmodule
